// File: hdl/sdt1rx_pkg.sv
// Package for the DT1 system-exclusive receive parser.
// Holds field widths, parse step codes, header bytes and the value length rule.
// No dependencies.
package sdt1rx_pkg;

    localparam int BYTE_W  = 8;
    localparam int SUM_W   = 7;
    localparam int ADDR_W  = 31;
    localparam int VALUE_W = 15;
    localparam int STEP_W  = 4;

    typedef logic [STEP_W-1:0]  t_step;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [SUM_W-1:0]   t_sum;

    localparam t_step STEP_IDLE     = 4'd0;
    localparam t_step STEP_HDR_END  = 4'd6;
    localparam t_step STEP_ADDR_END = 4'd10;

    localparam t_byte REALTIME_MIN = 8'hF8;

    localparam t_addr LEN_MASK      = 31'h7FFF_F8FF;
    localparam t_addr LEN_BLOCK     = 31'h0040_0000;
    localparam t_addr REMAP_FROM    = 31'h0040_0000;
    localparam t_addr REMAP_TO      = 31'h0040_4000;

    function automatic t_byte hdr_byte(input logic [2:0] idx);
        t_byte b;
        b = 8'h00;
        unique case (idx)
            3'd0: b = 8'hF0;
            3'd1: b = 8'h41;
            3'd2: b = 8'h10;
            3'd3: b = 8'h00;
            3'd4: b = 8'h11;
            3'd5: b = 8'h12;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Step code of the checksum byte for a given address.
    function automatic t_step checksum_step(input t_addr addr);
        logic two;
        two = ((addr & LEN_MASK) == LEN_BLOCK) && (addr[10:8] != 3'd0);
        return two ? STEP_ADDR_END + 4'd2 : STEP_ADDR_END + 4'd1;
    endfunction

endpackage

// File: hdl/sysex_dt1_receive_parser_unit.sv
// Top level of the DT1 system-exclusive receive parser.
// A result is presented in the cycle after the transfer of its checksum byte.
// Throughput: one byte per cycle, except that while
// a result waits on a stalled output, no further byte is taken from the input buffer.
// Reset (synchronous, active low) returns the parser to idle and empties both
// the input buffer and the result register.
// Depends on sdt1rx_pkg and sdt1rx_in_buf.
module sysex_dt1_receive_parser_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sdt1rx_pkg::t_byte     i_in_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sdt1rx_pkg::t_addr     o_param_address,
    output sdt1rx_pkg::t_value    o_param_value
);

    logic                buf_valid;
    sdt1rx_pkg::t_byte   buf_byte;
    logic                take;
    logic                out_free;

    sdt1rx_pkg::t_step   r_step;
    sdt1rx_pkg::t_step   n_step;
    sdt1rx_pkg::t_addr   r_addr;
    sdt1rx_pkg::t_addr   n_addr;
    sdt1rx_pkg::t_value  r_value;
    sdt1rx_pkg::t_value  n_value;
    sdt1rx_pkg::t_sum    r_sum;
    sdt1rx_pkg::t_sum    n_sum;
    sdt1rx_pkg::t_step   cks_step;
    logic                hit;
    sdt1rx_pkg::t_addr   hit_addr;

    logic                r_out_valid;
    sdt1rx_pkg::t_addr   r_out_addr;
    sdt1rx_pkg::t_value  r_out_value;

    sdt1rx_in_buf u_in_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_byte   (i_in_byte),
        .o_in_stall  (o_in_stall),
        .o_buf_valid (buf_valid),
        .o_buf_byte  (buf_byte),
        .i_buf_take  (take)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign take     = buf_valid && out_free;
    assign cks_step = sdt1rx_pkg::checksum_step(r_addr);
    assign hit_addr = (r_addr == sdt1rx_pkg::REMAP_FROM) ? sdt1rx_pkg::REMAP_TO : r_addr;

    always_comb begin
        n_step  = r_step;
        n_addr  = r_addr;
        n_value = r_value;
        n_sum   = r_sum;
        hit     = 1'b0;
        priority if (buf_byte >= sdt1rx_pkg::REALTIME_MIN) begin
            n_step = r_step;
        end else if (r_step < sdt1rx_pkg::STEP_HDR_END) begin
            n_step  = (buf_byte == sdt1rx_pkg::hdr_byte(r_step[2:0]))
                      ? r_step + 4'd1 : sdt1rx_pkg::STEP_IDLE;
            n_addr  = '0;
            n_value = '0;
            n_sum   = '0;
        end else if (r_step < sdt1rx_pkg::STEP_ADDR_END) begin
            n_step = buf_byte[7] ? sdt1rx_pkg::STEP_IDLE : r_step + 4'd1;
            n_addr = {r_addr[sdt1rx_pkg::ADDR_W-9:0], buf_byte};
            n_sum  = r_sum - buf_byte[6:0];
        end else if (r_step < cks_step) begin
            n_step  = buf_byte[7] ? sdt1rx_pkg::STEP_IDLE : r_step + 4'd1;
            n_value = {r_value[sdt1rx_pkg::VALUE_W-9:0], buf_byte};
            n_sum   = r_sum - buf_byte[6:0];
        end else if (r_step == cks_step) begin
            hit    = (buf_byte == {1'b0, r_sum});
            n_step = sdt1rx_pkg::STEP_IDLE;
        end else begin
            n_step = sdt1rx_pkg::STEP_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= sdt1rx_pkg::STEP_IDLE;
            r_addr      <= '0;
            r_value     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_step      <= n_step;
                r_addr      <= n_addr;
                r_value     <= n_value;
                r_sum       <= n_sum;
                r_out_valid <= hit;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && hit) begin
            r_out_addr  <= hit_addr;
            r_out_value <= r_value;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_param_address = r_out_addr;
    assign o_param_value   = r_out_value;

endmodule

// File: hdl/sdt1rx_in_buf.sv
// Two-entry input buffer for the DT1 receive parser.
// Registers the incoming byte and holds one spare so the stall output is a flop.
// Depends on sdt1rx_pkg.
module sdt1rx_in_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  sdt1rx_pkg::t_byte    i_in_byte,
    output logic                 o_in_stall,
    output logic                 o_buf_valid,
    output sdt1rx_pkg::t_byte    o_buf_byte,
    input  logic                 i_buf_take
);

    logic              r_main_valid;
    logic              r_skid_valid;
    sdt1rx_pkg::t_byte r_main_byte;
    sdt1rx_pkg::t_byte r_skid_byte;
    logic              accept;

    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign o_buf_valid = r_main_valid;
    assign o_buf_byte  = r_main_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_buf_take || !r_main_valid) begin
                if (r_skid_valid) begin
                    r_main_valid <= 1'b1;
                    r_skid_valid <= accept;
                end else begin
                    r_main_valid <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_buf_take || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main_byte <= r_skid_byte;
                if (accept) begin
                    r_skid_byte <= i_in_byte;
                end
            end else if (accept) begin
                r_main_byte <= i_in_byte;
            end
        end else if (accept) begin
            r_skid_byte <= i_in_byte;
        end
    end

endmodule

// File: dv/sysex_dt1_receive_parser_unit_test.sv
`timescale 1ns / 100ps
// Testbench for sysex_dt1_receive_parser_unit: DT1 messages, broken messages and noise
// go in, and each parameter write that comes out is checked against a built-in parser.
// Depends on sdt1rx_pkg and the parser RTL.
module sysex_dt1_receive_parser_unit_test;

    typedef struct packed {
        sdt1rx_pkg::t_addr  address;
        sdt1rx_pkg::t_value value;
    } t_param_write;

    typedef enum {
        FLAW_NONE,
        FLAW_BAD_SUM,
        FLAW_STATUS_SUM,
        FLAW_STATUS_BODY,
        FLAW_BAD_HEADER
    } t_msg_flaw;

    localparam logic [47:0]       DT1_HEADER        = 48'hF0_41_10_00_11_12;
    localparam sdt1rx_pkg::t_byte MIDI_REALTIME_MIN = 8'hF8;
    localparam sdt1rx_pkg::t_byte MIDI_STATUS_MIN   = 8'h80;
    localparam sdt1rx_pkg::t_byte MIDI_STATUS_MAX   = 8'hF7;
    localparam logic [31:0]       TWO_BYTE_MASK     = 32'hFFFF_F8FF;
    localparam logic [31:0]       TWO_BYTE_BLOCK    = 32'h0040_0000;
    localparam logic [31:0]       ADDR_REMAP_FROM   = 32'h0040_0000;
    localparam logic [31:0]       ADDR_REMAP_TO     = 32'h0040_4000;
    localparam int                STIMULUS_ITEMS    = 1800;
    localparam int                QUIET_LIMIT       = 1000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    sdt1rx_pkg::t_byte  i_in_byte = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    sdt1rx_pkg::t_addr  o_param_address;
    sdt1rx_pkg::t_value o_param_value;

    sdt1rx_pkg::t_byte midi_bytes_pending[$];
    t_param_write      expected_params[$];

    sdt1rx_pkg::t_step dt1_step = sdt1rx_pkg::STEP_IDLE;
    logic [31:0]       dt1_address = '0;
    logic [15:0]       dt1_value = '0;
    logic [6:0]        dt1_sum = '0;

    int stimulus_items = 0;
    int realtime_pct = 0;
    int total_bytes = 0;
    int bytes_accepted = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    sysex_dt1_receive_parser_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_param_address(o_param_address),
        .o_param_value  (o_param_value)
    );

    always #6 i_clk = ~i_clk;

    function automatic sdt1rx_pkg::t_byte header_byte(input int idx);
        return DT1_HEADER[47 - 8 * idx -: 8];
    endfunction

    function automatic sdt1rx_pkg::t_byte rand_data7();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'h7F;
            default: return sdt1rx_pkg::t_byte'($urandom_range(0, 127));
        endcase
    endfunction

    // Idle percentages for the three phases of the run.
    function automatic int idle_pct(input bit sender);
        if (bytes_accepted < total_bytes / 3) begin
            return sender ? 23 : 67;
        end else if (bytes_accepted < 2 * total_bytes / 3) begin
            return sender ? 67 : 23;
        end
        return 0;
    endfunction

    task automatic parse_midi_byte(input sdt1rx_pkg::t_byte b);
        logic              two_byte;
        sdt1rx_pkg::t_step sum_step;
        t_param_write      w;
        if (b >= MIDI_REALTIME_MIN) begin
            return;
        end
        two_byte = ((dt1_address & TWO_BYTE_MASK) == TWO_BYTE_BLOCK)
                   && (dt1_address[10:8] != 3'd0);
        sum_step = sdt1rx_pkg::STEP_ADDR_END + (two_byte ? 4'd2 : 4'd1);
        if (dt1_step < sdt1rx_pkg::STEP_HDR_END) begin
            dt1_step = (b == header_byte(dt1_step))
                       ? dt1_step + 4'd1 : sdt1rx_pkg::STEP_IDLE;
            dt1_address = '0;
            dt1_value = '0;
            dt1_sum = '0;
        end else if (dt1_step < sdt1rx_pkg::STEP_ADDR_END) begin
            dt1_step = b[7] ? sdt1rx_pkg::STEP_IDLE : dt1_step + 4'd1;
            dt1_address = {dt1_address[23:0], b};
            dt1_sum = dt1_sum - b[6:0];
        end else if (dt1_step < sum_step) begin
            dt1_step = b[7] ? sdt1rx_pkg::STEP_IDLE : dt1_step + 4'd1;
            dt1_value = {dt1_value[7:0], b};
            dt1_sum = dt1_sum - b[6:0];
        end else begin
            if (dt1_step == sum_step && b == {1'b0, dt1_sum}) begin
                if (dt1_address == ADDR_REMAP_FROM) begin
                    dt1_address = ADDR_REMAP_TO;
                end
                w.address = dt1_address[30:0];
                w.value = dt1_value[14:0];
                expected_params.push_back(w);
            end
            dt1_step = sdt1rx_pkg::STEP_IDLE;
        end
    endtask

    task automatic queue_midi_byte(input sdt1rx_pkg::t_byte b);
        if ($urandom_range(0, 99) < realtime_pct) begin
            midi_bytes_pending.push_back(
                sdt1rx_pkg::t_byte'($urandom_range(MIDI_REALTIME_MIN, 8'hFF)));
        end
        midi_bytes_pending.push_back(b);
        if (b < MIDI_REALTIME_MIN) begin
            stimulus_items++;
        end
    endtask

    task automatic queue_dt1_message(input sdt1rx_pkg::t_byte a0, a1, a2, a3, v0, v1,
                                     input t_msg_flaw flaw);
        sdt1rx_pkg::t_byte body [6];
        int                body_len;
        int                bad_pos;
        int                i;
        logic [6:0]        sum;
        sdt1rx_pkg::t_byte b;
        body = '{a0, a1, a2, a3, v0, v1};
        body_len = (a0 == 8'h00 && a1 == 8'h40 && a2[7:3] == 5'd0 && a2[2:0] != 3'd0)
                   ? 6 : 5;
        bad_pos = $urandom_range(0, (flaw == FLAW_STATUS_BODY) ? body_len - 1 : 5);
        for (i = 0; i < 6; i++) begin
            b = header_byte(i);
            if (flaw == FLAW_BAD_HEADER && i == bad_pos) begin
                do begin
                    b = sdt1rx_pkg::t_byte'($urandom_range(0, MIDI_STATUS_MAX));
                end while (b == header_byte(i));
            end
            queue_midi_byte(b);
        end
        sum = '0;
        for (i = 0; i < body_len; i++) begin
            b = body[i];
            if (flaw == FLAW_STATUS_BODY && i == bad_pos) begin
                b = sdt1rx_pkg::t_byte'($urandom_range(MIDI_STATUS_MIN, MIDI_STATUS_MAX));
            end
            sum = sum - b[6:0];
            queue_midi_byte(b);
        end
        case (flaw)
            FLAW_BAD_SUM: b = {1'b0, sum ^ 7'($urandom_range(1, 127))};
            FLAW_STATUS_SUM: begin
                b = sdt1rx_pkg::t_byte'($urandom_range(MIDI_STATUS_MIN, MIDI_STATUS_MAX));
            end
            default: b = {1'b0, sum};
        endcase
        queue_midi_byte(b);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            dt1_step = sdt1rx_pkg::STEP_IDLE;
            dt1_address = '0;
            dt1_value = '0;
            dt1_sum = '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                parse_midi_byte(i_in_byte);
                bytes_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (midi_bytes_pending.size() != 0
                        && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                    i_in_valid <= 1'b1;
                    i_in_byte <= midi_bytes_pending.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
        end
    end

    always @(posedge i_clk) begin
        t_param_write w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_params.size() == 0) begin
                $display("%0t: unexpected parameter write: expected none, actual %h / %h",
                         $time, o_param_address, o_param_value);
                mismatch_count++;
            end else begin
                w = expected_params.pop_front();
                if (o_param_address !== w.address) begin
                    $display("%0t: param_address mismatch: expected %h, actual %h",
                             $time, w.address, o_param_address);
                    mismatch_count++;
                end
                if (o_param_value !== w.value) begin
                    $display("%0t: param_value mismatch: expected %h, actual %h",
                             $time, w.value, o_param_value);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        sdt1rx_pkg::t_byte a0, a1, a2, a3, v0, v1;
        t_msg_flaw         flaw;
        int                r;
        int                n;
        int                i;

        // A header broken by a repeated F0, then a remapped address and a
        // two-byte value with real-time bytes mixed in.
        queue_midi_byte(8'hF0);
        queue_midi_byte(8'hF0);
        queue_dt1_message(8'h00, 8'h40, 8'h00, 8'h00, 8'h7F, 8'h00, FLAW_NONE);
        realtime_pct = 50;
        queue_dt1_message(8'h00, 8'h40, 8'h07, 8'h00, 8'h7F, 8'h7F, FLAW_NONE);

        realtime_pct = 3;
        while (stimulus_items < STIMULUS_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r >= 88) begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    queue_midi_byte(sdt1rx_pkg::t_byte'($urandom_range(0, 255)));
                end
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    a0 = 8'h00;
                    a1 = 8'h40;
                    a2 = sdt1rx_pkg::t_byte'($urandom_range(0, 9));
                    a3 = ($urandom_range(0, 3) == 0) ? 8'h00 : rand_data7();
                end else begin
                    a0 = rand_data7();
                    a1 = rand_data7();
                    a2 = rand_data7();
                    a3 = rand_data7();
                end
                v0 = rand_data7();
                v1 = rand_data7();
                if (r < 70) begin
                    flaw = FLAW_NONE;
                end else if (r < 74) begin
                    flaw = FLAW_BAD_SUM;
                end else if (r < 78) begin
                    flaw = FLAW_STATUS_SUM;
                end else if (r < 84) begin
                    flaw = FLAW_STATUS_BODY;
                end else begin
                    flaw = FLAW_BAD_HEADER;
                end
                queue_dt1_message(a0, a1, a2, a3, v0, v1, flaw);
            end
        end
        total_bytes = midi_bytes_pending.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (midi_bytes_pending.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_params.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/sdt1rx_pkg.sv
hdl/sdt1rx_in_buf.sv
hdl/sysex_dt1_receive_parser_unit.sv
dv/sysex_dt1_receive_parser_unit_test.sv
